@@ rtl/rttfp_pkg.sv @@
// Package: shared types, character codes, status codes and defaults for the radix text parser.
package rttfp_pkg;

    localparam int DEFAULT_INT_BITS  = 32;
    localparam int DEFAULT_FRAC_BITS = 32;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [4:0] DIGIT_TEN  = 5'd10;

    localparam logic [1:0] RADIX_BIN   = 2'd0;
    localparam logic [1:0] RADIX_OCT   = 2'd1;
    localparam logic [1:0] RADIX_HEX   = 2'd2;
    localparam logic [1:0] RADIX_RESET = RADIX_HEX;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } result_t;

endpackage

@@ rtl/rttfp_in_reg.sv @@
// Input register: holds one accepted character and releases it to the parser.
module rttfp_in_reg
    import rttfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       out_free,
    output item_t      item,
    output logic       go
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Only a final character can wait, and only on a full result register.
    assign go       = valid_reg && (!item_reg.is_last || out_free);
    assign in_stall = valid_reg && !go;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (go)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.char_code <= char_code;
            item_reg.is_last   <= is_last;
        end
    end

endmodule

@@ rtl/rttfp_parser.sv @@
// Parser: radix register, parse state and the one-character update of the accumulator.
module rttfp_parser
    import rttfp_pkg::*;
#(
    parameter int INT_BITS  = DEFAULT_INT_BITS,
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       go,
    input  item_t      item,
    output result_t    result
);

    localparam int W  = (INT_BITS + FRAC_BITS > 64) ? 64 : INT_BITS + FRAC_BITS;
    localparam int IW = W - FRAC_BITS;
    localparam int FW = $clog2(FRAC_BITS + 1);
    localparam int EW = $clog2(FRAC_BITS + 5);
    localparam logic [W-1:0] TOP = W'(1) << (W - 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC
    } phase_t;

    logic [1:0]  radix_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        neg_reg;
    logic        neg_next;
    logic [W-1:0] mag_reg;
    logic [W-1:0] mag_next;
    logic [FW-1:0] fbu_reg;
    logic [FW-1:0] fbu_next;
    logic [1:0]  err_reg;
    logic [1:0]  err_next;

    logic [4:0]      digit;
    logic [2:0]      bits;
    logic [W-1:0]    cap;
    logic [IW+3:0]   nip;
    logic [EW-1:0]   end_pos;
    logic [FRAC_BITS+3:0] frac_shift;
    logic [FRAC_BITS-1:0] add;
    logic [W:0]      sum;
    logic signed [W-1:0] signed_val;

    // 0-15 for a digit, 16 for anything else.
    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = 5'(c - CHAR_0);
        end
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
        begin
            d = 5'(c - CHAR_UC_A) + DIGIT_TEN;
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
        begin
            d = 5'(c - CHAR_LC_A) + DIGIT_TEN;
        end
        return d;
    endfunction

    function automatic logic [2:0] radix_bits(input logic [1:0] r);
        logic [2:0] b;
        unique case (r)
            RADIX_BIN: b = 3'd1;
            RADIX_OCT: b = 3'd3;
            default:   b = 3'd4;
        endcase
        return b;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        fbu_next   = fbu_reg;
        err_next   = err_reg;

        digit = decode_digit(item.char_code);
        bits  = radix_bits(radix_reg);
        cap   = neg_reg ? TOP : TOP - W'(1);

        // Integer digit: shift the integer part up and add the digit.
        nip = ((IW+4)'(mag_reg[W-1:FRAC_BITS]) << bits) + (IW+4)'(digit[3:0]);

        // Fraction digit: place it just below the bits already used, truncate the rest.
        end_pos    = EW'(fbu_reg) + EW'(bits);
        frac_shift = {digit[3:0], {FRAC_BITS{1'b0}}} >> end_pos;
        add        = frac_shift[FRAC_BITS-1:0];
        sum        = (W+1)'(mag_reg) + (W+1)'(add);

        if (err_reg == STATUS_OK)
        begin
            if (item.char_code == CHAR_MINUS)
            begin
                if (phase_reg == PH_START)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                end
                else
                begin
                    err_next = STATUS_BAD_CHAR;
                end
            end
            else if (item.char_code == CHAR_POINT)
            begin
                if (phase_reg == PH_FRAC)
                begin
                    err_next = STATUS_BAD_CHAR;
                end
                else
                begin
                    phase_next = PH_FRAC;
                end
            end
            else if (digit[4])
            begin
                err_next = STATUS_BAD_CHAR;
            end
            else if ((digit[3:0] >> bits) != 4'd0)
            begin
                err_next = STATUS_BAD_DIGIT;
            end
            else if (phase_reg != PH_FRAC)
            begin
                phase_next = PH_INT;
                if (nip > (IW+4)'(cap[W-1:FRAC_BITS]))
                begin
                    mag_next = cap;
                    err_next = STATUS_OVERFLOW;
                end
                else
                begin
                    mag_next = {nip[IW-1:0], {FRAC_BITS{1'b0}}};
                end
            end
            else if (fbu_reg < FW'(FRAC_BITS))
            begin
                fbu_next = (end_pos > EW'(FRAC_BITS)) ? FW'(FRAC_BITS) : FW'(end_pos);
                if (sum > (W+1)'(cap))
                begin
                    mag_next = cap;
                    err_next = STATUS_OVERFLOW;
                end
                else
                begin
                    mag_next = sum[W-1:0];
                end
            end
        end

        signed_val = neg_next ? -mag_next : mag_next;
        if (err_next == STATUS_BAD_CHAR || err_next == STATUS_BAD_DIGIT)
        begin
            result.value = 64'd0;
        end
        else
        begin
            result.value = 64'(signed_val);
        end
        result.status = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            fbu_reg   <= '0;
            err_reg   <= STATUS_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (go)
            begin
                if (item.is_last)
                begin
                    phase_reg <= PH_START;
                    neg_reg   <= 1'b0;
                    mag_reg   <= '0;
                    fbu_reg   <= '0;
                    err_reg   <= STATUS_OK;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    fbu_reg   <= fbu_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

endmodule

@@ rtl/rttfp_out_reg.sv @@
// Result register: holds one finished number until the receiver takes it.
module rttfp_out_reg
    import rttfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic [1:0]  status
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign value     = result_reg.value;
    assign status    = result_reg.status;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ rtl/radix_text_to_fixed_point_top.sv @@
// Top level: radix text to fixed-point parser, input register, parser and result register.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid / in_stall  char_code[7:0], is_last
//  out      source     out_valid/out_stall  value[63:0] (signed Q INT.FRAC), status[1:0]
//  cfg      sink       cfg_we               cfg_wdata[1:0] (radix select)
//
// One character per cycle while in is not stalled: a character is registered on
// transfer and then folded into the accumulator. The result of a final character
// is captured in the result register, which drives out.
// Reset clears the parse state and sets the radix to hexadecimal.
// A stall on out holds the result; in stalls only when a final character meets
// a full, stalled result register. Other characters keep flowing.
module radix_text_to_fixed_point_top
    import rttfp_pkg::*;
#(
    parameter int INT_BITS  = DEFAULT_INT_BITS,
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic [1:0]  status
);

    item_t   item;
    result_t result;
    logic    go;
    logic    out_free;

    // Hold the transferred character until the parser takes it.
    rttfp_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .is_last   (is_last),
        .out_free  (out_free),
        .item      (item),
        .go        (go)
    );

    // Advance the parse state and form the result of a final character.
    rttfp_parser #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .go        (go),
        .item      (item),
        .result    (result)
    );

    // Capture the result when a final character is processed.
    rttfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go && item.is_last),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

endmodule

@@ rtl/rttfp_checker.sv @@
// Checker: port-level properties of the radix text parser, bound to the top level.
module rttfp_checker
    import rttfp_pkg::*;
#(
    parameter int INT_BITS  = DEFAULT_INT_BITS,
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] value,
    input logic [1:0]  status
);

    localparam int W = (INT_BITS + FRAC_BITS > 64) ? 64 : INT_BITS + FRAC_BITS;
    localparam logic [63:0] POS_MAX = 64'((65'd1 << (W - 1)) - 65'd1);
    localparam logic [63:0] NEG_MIN = ~POS_MAX;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

    // The input side only waits behind a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // Character and digit errors carry a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_BAD_CHAR || status == STATUS_BAD_DIGIT)
            |-> value == 64'd0)
        else $error("error result with non-zero value");

    // Overflow yields one of the two saturation limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OVERFLOW |-> value == POS_MAX || value == NEG_MIN)
        else $error("overflow result not saturated");

    // Every value lies inside the fixed-point range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(value) <= $signed(POS_MAX) && $signed(value) >= $signed(NEG_MIN))
        else $error("result outside fixed-point range");

endmodule

bind radix_text_to_fixed_point_top rttfp_checker #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_rttfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);
